// ===== rtl/block_rms_meter_assert.svh =====
// assertion macros for the rms level meter
`ifndef BLOCK_RMS_METER_ASSERT_SVH
`define BLOCK_RMS_METER_ASSERT_SVH

// property that holds at every clock edge outside reset
`define RMS_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define RMS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rms_pkg.sv =====
// shared constants for the rms level meter
`timescale 1ns / 1ps
package rms_pkg;
	localparam int GAIN_BITS = 16;
	localparam int ACC_BITS = 64;
	localparam int ROOT_BITS = ACC_BITS / 2;
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_MAX_BLOCK_SAMPLES = 65536;
	localparam int DEF_GAIN_FRAC_BITS = 12;

	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd4096;

	// register index taken from paddr above the byte offset
	localparam logic REG_GAIN_IDX = 1'b0;
endpackage

// ===== rtl/block_rms_meter.sv =====
// block rms level meter top level with apb gain register and output register
//
// s_tdata carries one signed sample per word, any channel, interleaved freely;
// s_tlast marks the last sample of a measured block. Each sample is scaled by
// the calibration gain (Q4.12, apb register at address 0, reset to unity),
// clamped, squared and summed into a saturating 64-bit accumulator.
// For each sample a bit-serial shift-add unit runs the gain multiply and then
// the square. s_tready is high only while that unit is idle.
// After a tlast word the sum and count pass to a bit-serial divider and then
// to a bit-serial root unit; the result word is loaded from the root unit into
// the output register, which drives m_tdata.
// Samples of the next block are taken while the divide and root run.
// A finished result sits in the output register until m_tready; a stalled
// receiver holds the root unit, then the accumulator's hand-over, then input.
// Reset clears sums, count, all control and sets the gain to unity.
`timescale 1ns / 1ps
`include "block_rms_meter_assert.svh"
module block_rms_meter import rms_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int MAX_BLOCK_SAMPLES = DEF_MAX_BLOCK_SAMPLES,
	parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
	localparam int COUNT_BITS = $clog2(MAX_BLOCK_SAMPLES + 1),
	localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int M_TDATA_W = ((SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [S_TDATA_W-1:0]     s_tdata,  // sample
	input  logic                     s_tlast,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [M_TDATA_W-1:0]     m_tdata   // rms_level, sample_count
);
	logic [GAIN_BITS-1:0]   gain_q;
	logic                   cfg_wr;

	logic                   blk_valid;
	logic                   blk_ready;
	logic [ACC_BITS-1:0]    blk_sum;
	logic [COUNT_BITS-1:0]  blk_count;
	logic [COUNT_BITS-1:0]  pend_count_q;

	logic                   div_busy;
	logic                   div_done;
	logic [ACC_BITS-1:0]    quotient;

	logic                   sqrt_busy;
	logic                   sqrt_valid;
	logic                   sqrt_ready;
	logic [ROOT_BITS-1:0]   root;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_rms_q;
	logic [COUNT_BITS-1:0]  out_count_q;

	// gain register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[APB_ADDR_BITS-1] == REG_GAIN_IDX) ? APB_DATA_BITS'(gain_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_wr && paddr[APB_ADDR_BITS-1] == REG_GAIN_IDX) begin
			gain_q <= pwdata[GAIN_BITS-1:0];
		end
	end

	rms_mac #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_sample(s_tdata[SAMPLE_BITS-1:0]),
		.in_last(s_tlast),
		.gain(gain_q),
		.blk_valid(blk_valid),
		.blk_ready(blk_ready),
		.blk_sum(blk_sum),
		.blk_count(blk_count)
	);

	// the divide and root path holds one block at a time
	assign blk_ready = ~(div_busy | div_done | sqrt_busy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_count_q <= '0;
		end else if (blk_valid && blk_ready) begin
			pend_count_q <= blk_count;
		end
	end

	rms_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(blk_valid & blk_ready),
		.dividend(blk_sum),
		.divisor(blk_count),
		.busy(div_busy),
		.done(div_done),
		.quotient(quotient)
	);

	rms_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_done),
		.radicand(quotient),
		.busy(sqrt_busy),
		.out_valid(sqrt_valid),
		.out_ready(sqrt_ready),
		.root(root)
	);

	// output register
	assign sqrt_ready = ~out_valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_rms_q <= '0;
			out_count_q <= '0;
		end else if (sqrt_valid && sqrt_ready) begin
			out_valid_q <= 1'b1;
			out_rms_q <= root[SAMPLE_BITS-1:0];
			out_count_q <= pend_count_q;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = M_TDATA_W'({out_count_q, out_rms_q});

	`RMS_ASSERT(a_path_single, clk, arst_n, !(div_busy && sqrt_busy), "divider and root unit both busy")
	`RMS_ASSERT_NEXT(a_hand_starts_div, clk, arst_n, blk_valid && blk_ready, div_busy, "hand-over did not start the divider")
	`RMS_ASSERT_NEXT(a_root_loads_out, clk, arst_n, sqrt_valid && sqrt_ready, m_tvalid, "root result not loaded into output register")
	`RMS_ASSERT(a_count_nonzero, clk, arst_n, !out_valid_q || (out_count_q != '0), "result word with zero sample count")
endmodule

// ===== rtl/rms_mac.sv =====
// bit-serial gain scaling, squaring and saturating accumulation
`timescale 1ns / 1ps
module rms_mac import rms_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int MAX_BLOCK_SAMPLES = DEF_MAX_BLOCK_SAMPLES,
	parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
	localparam int COUNT_BITS = $clog2(MAX_BLOCK_SAMPLES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic                   in_last,
	input  logic [GAIN_BITS-1:0]   gain,
	output logic                   blk_valid,
	input  logic                   blk_ready,
	output logic [ACC_BITS-1:0]    blk_sum,
	output logic [COUNT_BITS-1:0]  blk_count
);
	localparam int LO_W = (SAMPLE_BITS > GAIN_BITS) ? SAMPLE_BITS : GAIN_BITS;
	localparam int STEP_W = $clog2(LO_W + 1);
	localparam int PW = SAMPLE_BITS + GAIN_BITS;
	localparam int QW = PW - GAIN_FRAC_BITS;
	localparam int SQ_W = 2 * SAMPLE_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_BLOCK_SAMPLES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CLAMP,
		ST_SQR,
		ST_ACC,
		ST_HAND
	} state_t;

	state_t                  state_q;
	logic [STEP_W-1:0]       step_q;
	logic                    last_q;
	logic signed [SAMPLE_BITS:0] mcand_q;
	logic [LO_W-1:0]         mplr_q;
	logic signed [SAMPLE_BITS:0] hi_q;
	logic [LO_W-1:0]         lo_q;
	logic [ACC_BITS-1:0]     sum_q;
	logic [COUNT_BITS-1:0]   count_q;

	logic signed [SAMPLE_BITS:0]   addend;
	logic signed [SAMPLE_BITS+1:0] add_s;
	logic [PW-1:0]                 prod;
	logic [QW-1:0]                 scaled;
	logic [QW-SAMPLE_BITS:0]       scaled_top;
	logic                          in_range;
	logic [SAMPLE_BITS-1:0]        clamped;
	logic [SAMPLE_BITS-1:0]        mag;
	logic [SQ_W-1:0]               square;
	logic [ACC_BITS:0]             acc_s;
	logic [ACC_BITS-1:0]           sum_next;
	logic [COUNT_BITS-1:0]         count_next;

	// one shift-add step per cycle
	always_comb begin
		addend = mplr_q[0] ? mcand_q : '0;
		add_s = {hi_q[SAMPLE_BITS], hi_q} + {addend[SAMPLE_BITS], addend};
	end

	// floor shift of the scaled product, then clamp to the sample range
	always_comb begin
		prod = {hi_q[SAMPLE_BITS-1:0], lo_q[LO_W-1 -: GAIN_BITS]};
		scaled = prod[PW-1:GAIN_FRAC_BITS];
		scaled_top = scaled[QW-1:SAMPLE_BITS-1];
		in_range = (&scaled_top) | ~(|scaled_top);
		if (in_range) begin
			clamped = scaled[SAMPLE_BITS-1:0];
		end else if (scaled[QW-1]) begin
			clamped = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			clamped = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		mag = clamped[SAMPLE_BITS-1] ? (~clamped) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1} : clamped;
	end

	always_comb begin
		square = {hi_q[SAMPLE_BITS-1:0], lo_q[LO_W-1 -: SAMPLE_BITS]};
		acc_s = {1'b0, sum_q} + (ACC_BITS+1)'(square);
		sum_next = acc_s[ACC_BITS] ? '1 : acc_s[ACC_BITS-1:0];
		count_next = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			last_q <= 1'b0;
			mcand_q <= '0;
			mplr_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			sum_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mcand_q <= {in_sample[SAMPLE_BITS-1], in_sample};
						mplr_q <= LO_W'(gain);
						hi_q <= '0;
						step_q <= '0;
						last_q <= in_last;
						state_q <= ST_MUL;
					end
				end
				ST_MUL, ST_SQR: begin
					hi_q <= add_s[SAMPLE_BITS+1:1];
					lo_q <= {add_s[0], lo_q[LO_W-1:1]};
					mplr_q <= mplr_q >> 1;
					step_q <= step_q + 1'b1;
					if (state_q == ST_MUL && step_q == STEP_W'(GAIN_BITS - 1)) begin
						state_q <= ST_CLAMP;
					end else if (state_q == ST_SQR && step_q == STEP_W'(SAMPLE_BITS - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_CLAMP: begin
					mcand_q <= {1'b0, mag};
					mplr_q <= LO_W'(mag);
					hi_q <= '0;
					step_q <= '0;
					state_q <= ST_SQR;
				end
				ST_ACC: begin
					sum_q <= sum_next;
					count_q <= count_next;
					state_q <= last_q ? ST_HAND : ST_IDLE;
				end
				ST_HAND: begin
					if (blk_ready) begin
						sum_q <= '0;
						count_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign blk_valid = (state_q == ST_HAND);
	assign blk_sum = sum_q;
	assign blk_count = count_q;
endmodule

// ===== rtl/rms_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rms_div import rms_pkg::*; #(
	parameter int COUNT_BITS = $clog2(DEF_MAX_BLOCK_SAMPLES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ACC_BITS-1:0]   dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [ACC_BITS-1:0]   quotient
);
	localparam int STEP_W = $clog2(ACC_BITS);

	typedef enum logic {
		DV_IDLE,
		DV_RUN
	} state_t;

	state_t                state_q;
	logic [STEP_W-1:0]     step_q;
	logic [ACC_BITS-1:0]   dvd_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] dsr_q;
	logic                  done_q;

	logic [COUNT_BITS:0] trial;
	logic [COUNT_BITS:0] diff;
	logic                fits;

	always_comb begin
		trial = {rem_q, dvd_q[ACC_BITS-1]};
		diff = trial - {1'b0, dsr_q};
		fits = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			step_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			dsr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (start) begin
						dvd_q <= dividend;
						dsr_q <= divisor;
						rem_q <= '0;
						step_q <= '0;
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					rem_q <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
					dvd_q <= {dvd_q[ACC_BITS-2:0], fits};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ACC_BITS - 1)) begin
						done_q <= 1'b1;
						state_q <= DV_IDLE;
					end
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == DV_RUN);
	assign done = done_q;
	assign quotient = dvd_q;
endmodule

// ===== rtl/rms_sqrt.sv =====
// digit-by-digit integer square root, one root bit per cycle
`timescale 1ns / 1ps
module rms_sqrt import rms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ACC_BITS-1:0]  radicand,
	output logic                 busy,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ROOT_BITS-1:0] root
);
	localparam int STEP_W = $clog2(ROOT_BITS);

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_DONE
	} state_t;

	state_t               state_q;
	logic [STEP_W-1:0]    step_q;
	logic [ACC_BITS-1:0]  x_q;
	logic [ROOT_BITS:0]   rem_q;
	logic [ROOT_BITS-1:0] root_q;

	logic [ROOT_BITS+1:0] trial_rem;
	logic [ROOT_BITS+1:0] trial_sub;
	logic [ROOT_BITS+1:0] diff;
	logic                 fits;

	// remainder stays at most twice the partial root, so its top bit is zero here
	always_comb begin
		trial_rem = {rem_q[ROOT_BITS-1:0], x_q[ACC_BITS-1 -: 2]};
		trial_sub = {root_q, 2'b01};
		diff = trial_rem - trial_sub;
		fits = (trial_rem >= trial_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			step_q <= '0;
			x_q <= '0;
			rem_q <= '0;
			root_q <= '0;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					if (start) begin
						x_q <= radicand;
						rem_q <= '0;
						root_q <= '0;
						step_q <= '0;
						state_q <= SQ_RUN;
					end
				end
				SQ_RUN: begin
					rem_q <= fits ? diff[ROOT_BITS:0] : trial_rem[ROOT_BITS:0];
					root_q <= {root_q[ROOT_BITS-2:0], fits};
					x_q <= {x_q[ACC_BITS-3:0], 2'b00};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ROOT_BITS - 1)) begin
						state_q <= SQ_DONE;
					end
				end
				SQ_DONE: begin
					if (out_ready) begin
						state_q <= SQ_IDLE;
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != SQ_IDLE);
	assign out_valid = (state_q == SQ_DONE);
	assign root = root_q;
endmodule
